// ===== rtl/mmft_pkg.sv =====
// ----------------------------------------------------------------------------
// Mail message field tokenizer package
// Shared request types, parser state, token codes and delimiter tables.
// ----------------------------------------------------------------------------
package mmft_pkg;

    localparam int BUF_DEPTH = 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       at_file_end;
    } src_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } tok_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
    } res_t;

    typedef enum logic [2:0] {
        M_LINE,
        M_NAME,
        M_COLON,
        M_TEXT,
        M_SEP,
        M_BODY,
        M_SKIP,
        M_ERROR
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_REPLAY,
        SEQ_LAST
    } seq_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  style;
        logic [9:0]  name_cnt;
        logic [15:0] chunk_cnt;
        logic [2:0]  match_cnt;
        logic        nl_pend;
        logic        line_start;
        logic        msg_open;
    } st_t;

    localparam logic [3:0] TK_NAME        = 4'd0;
    localparam logic [3:0] TK_TEXT        = 4'd1;
    localparam logic [3:0] TK_BODY        = 4'd2;
    localparam logic [3:0] TK_FIELD_END   = 4'd3;
    localparam logic [3:0] TK_FIELD_CHUNK = 4'd4;
    localparam logic [3:0] TK_LINE_BODY   = 4'd5;
    localparam logic [3:0] TK_MSG_END     = 4'd6;
    localparam logic [3:0] TK_FORMAT_ERR  = 4'd7;
    localparam logic [3:0] TK_LENGTH_ERR  = 4'd8;
    localparam logic [3:0] TK_FILE_END    = 4'd9;
    localparam logic [3:0] TK_BODY_CHUNK  = 4'd10;

    localparam logic [1:0] STYLE_SINGLE = 2'd0;
    localparam logic [1:0] STYLE_DETECT = 2'd1;
    localparam logic [1:0] STYLE_MBOX   = 2'd2;
    localparam logic [1:0] STYLE_CTLA   = 2'd3;

    localparam logic [1:0] REG_DROP_STYLE  = 2'd0;
    localparam logic [1:0] REG_NAME_LIMIT  = 2'd1;
    localparam logic [1:0] REG_CHUNK_LIMIT = 2'd2;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CTLA  = 8'h01;

    localparam logic [2:0] FROM_LEN = 3'd5;

    // "From "
    function automatic logic [7:0] from_byte(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'h46;
            3'd1:    r = 8'h72;
            3'd2:    r = 8'h6F;
            3'd3:    r = 8'h6D;
            3'd4:    r = CH_SPACE;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // mailbox: "\nFrom ", control-A: four control-A bytes and a newline
    function automatic logic [7:0] delim_byte(input logic [1:0] style, input logic [2:0] i);
        logic [7:0] r;
        if (style == STYLE_MBOX)
        begin
            if (i == 3'd0)
                r = CH_NL;
            else
                r = from_byte(3'(i - 3'd1));
        end
        else
        begin
            case (i)
                3'd0, 3'd1, 3'd2, 3'd3: r = CH_CTLA;
                3'd4:                   r = CH_NL;
                default:                r = 8'h00;
            endcase
        end
        return r;
    endfunction

    function automatic st_t start_state(input logic [1:0] style);
        st_t s;
        s.mode       = M_LINE;
        s.style      = style;
        s.name_cnt   = '0;
        s.chunk_cnt  = '0;
        s.match_cnt  = '0;
        s.nl_pend    = 1'b0;
        s.line_start = 1'b1;
        s.msg_open   = 1'b0;
        return s;
    endfunction

    function automatic res_t mk_res(input logic [3:0] kind, input logic [7:0] data);
        res_t r;
        r.kind = kind;
        r.data = data;
        return r;
    endfunction

endpackage

// ===== rtl/mail_message_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Mail message field tokenizer
// Takes a mail file one byte per request and returns a stream of tokens:
// name, field text and body bytes, field/chunk/message ends and errors.
// A byte is parsed in the cycle it is accepted unless held bytes must be
// replayed first, so bytes enter one per cycle while no replay runs and no
// built tokens wait. A byte that breaks a partial delimiter match (or ends
// style detection) stalls the input while the held bytes (at most MAX_DELIM,
// or four in style detection) are replayed through the single byte handler
// one per cycle before the byte itself. Tokens leave one per cycle, while
// tok_stall is low, from an eight-entry output buffer; a second eight-entry
// build buffer holds the next byte's tokens, stalling input until they move.
// ----------------------------------------------------------------------------
module mail_message_field_tokenizer
    import mmft_pkg::*;
#(
    parameter int MAX_DELIM = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  src_t        src_data,
    output logic        tok_valid,
    input  logic        tok_stall,
    output tok_t        tok_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DL_MBOX_I = 1 + ((MAX_DELIM < 5) ? MAX_DELIM : 5);
    localparam int DL_CTLA_I = 1 + ((MAX_DELIM < 4) ? MAX_DELIM : 4);
    localparam logic [2:0] DL_MBOX = 3'(DL_MBOX_I);
    localparam logic [2:0] DL_CTLA = 3'(DL_CTLA_I);

    logic [1:0]  drop_style_reg;
    logic [9:0]  name_limit_reg;
    logic [15:0] chunk_limit_reg;

    seq_t        phase_reg, phase_next;
    st_t         st_reg, st_next, st_pre, h_st;
    src_t        cur_reg;
    logic        cur_load;
    logic [2:0]  rep_idx_reg, rep_idx_next;
    logic [2:0]  rep_cnt_reg, rep_cnt_next;
    logic        rep_from_reg, rep_from_next;

    res_t [BUF_DEPTH-1:0] bld_reg, bld_next;
    logic [3:0]  bld_cnt_reg, bld_cnt_next;
    logic        bld_rdy_reg, bld_rdy_next;
    res_t [BUF_DEPTH-1:0] ob_reg;
    logic [3:0]  ob_cnt_reg, ob_cnt_next;
    logic [2:0]  ob_ptr_reg, ob_ptr_next;

    logic        take_in;
    logic        complete;
    logic        h_en;
    logic [7:0]  h_byte;
    logic        h_mm;
    res_t [2:0]  h_res, fe_res, nw;
    logic [1:0]  h_n, fe_n, nw_n;
    logic [15:0] chunk_eff;
    logic [3:0]  cnt_next;
    logic        out_fire, out_last, out_take;
    logic        move_bld, move_new;
    logic        cfg_wr;

    assign chunk_eff = (chunk_limit_reg < 16'd3) ? 16'd3 : chunk_limit_reg;
    assign src_stall = (phase_reg != SEQ_IDLE) || bld_rdy_reg;
    assign take_in   = src_valid && !src_stall;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    mmft_handle u_handle (
        .st         (st_pre),
        .b          (h_byte),
        .mm         (h_mm),
        .name_limit (name_limit_reg),
        .chunk_eff  (chunk_eff),
        .st_next    (h_st),
        .res        (h_res),
        .res_n      (h_n)
    );

    always_comb
    begin
        logic [2:0] k;
        logic [2:0] dl;
        logic       delimited;
        logic       fin;
        logic       start_rep;
        logic [2:0] rep_k;
        logic       rep_from;

        st_pre        = st_reg;
        h_en          = 1'b0;
        h_byte        = src_data.in_byte;
        h_mm          = 1'b1;
        complete      = 1'b0;
        phase_next    = phase_reg;
        rep_idx_next  = rep_idx_reg;
        rep_cnt_next  = rep_cnt_reg;
        rep_from_next = rep_from_reg;
        cur_load      = 1'b0;
        fe_res        = '0;
        fe_n          = 2'd0;
        fin           = 1'b0;
        start_rep     = 1'b0;
        rep_k         = 3'd0;
        rep_from      = 1'b0;
        k             = st_reg.match_cnt;
        dl            = (st_reg.style == STYLE_MBOX) ? DL_MBOX :
                        (st_reg.style == STYLE_CTLA) ? DL_CTLA : 3'd0;
        delimited     = (dl != 3'd0);

        case (phase_reg)
            SEQ_IDLE:
            begin
                if (take_in)
                begin
                    if (src_data.at_file_end)
                    begin
                        if (st_reg.style == STYLE_DETECT)
                        begin
                            st_pre.style     = STYLE_CTLA;
                            st_pre.match_cnt = 3'd0;
                            if (k != 3'd0)
                            begin
                                start_rep = 1'b1;
                                rep_from  = 1'b1;
                                rep_k     = k;
                            end
                            else
                                fin = 1'b1;
                        end
                        else if (k != 3'd0 && delimited)
                        begin
                            st_pre.match_cnt = 3'd0;
                            if (!(st_reg.style == STYLE_MBOX && k == 3'd1))
                            begin
                                start_rep = 1'b1;
                                rep_k     = k;
                            end
                            else
                                fin = 1'b1;
                        end
                        else
                            fin = 1'b1;
                    end
                    else if (st_reg.style == STYLE_DETECT)
                    begin
                        if (src_data.in_byte == from_byte(k))
                        begin
                            st_pre.match_cnt = 3'(k + 3'd1);
                            if (3'(k + 3'd1) == FROM_LEN)
                            begin
                                st_pre.style     = STYLE_MBOX;
                                st_pre.match_cnt = 3'd0;
                                st_pre.mode      = M_SKIP;
                            end
                            complete = 1'b1;
                        end
                        else
                        begin
                            st_pre.style     = STYLE_CTLA;
                            st_pre.match_cnt = 3'd0;
                            if (k != 3'd0)
                            begin
                                start_rep = 1'b1;
                                rep_from  = 1'b1;
                                rep_k     = k;
                            end
                            else
                            begin
                                h_en     = 1'b1;
                                complete = 1'b1;
                            end
                        end
                    end
                    else if (k != 3'd0 && delimited)
                    begin
                        if (k < dl && src_data.in_byte == delim_byte(st_reg.style, k))
                        begin
                            st_pre.match_cnt = 3'(k + 3'd1);
                            if (3'(k + 3'd1) >= dl)
                            begin
                                fe_res[0]         = mk_res(TK_MSG_END, 8'h00);
                                fe_n              = {1'b0, st_reg.msg_open};
                                st_pre.msg_open   = 1'b0;
                                st_pre.name_cnt   = '0;
                                st_pre.chunk_cnt  = '0;
                                st_pre.match_cnt  = 3'd0;
                                st_pre.nl_pend    = 1'b0;
                                st_pre.line_start = 1'b1;
                                st_pre.mode       = (st_reg.style == STYLE_MBOX) ? M_SKIP
                                                                                 : M_LINE;
                            end
                            complete = 1'b1;
                        end
                        else
                        begin
                            st_pre.match_cnt = 3'd0;
                            start_rep        = 1'b1;
                            rep_k            = k;
                        end
                    end
                    else
                    begin
                        st_pre.match_cnt = 3'd0;
                        h_en             = 1'b1;
                        complete         = 1'b1;
                    end
                end
            end
            SEQ_REPLAY:
            begin
                h_en         = 1'b1;
                h_byte       = rep_from_reg ? from_byte(rep_idx_reg)
                                            : delim_byte(st_reg.style, rep_idx_reg);
                h_mm         = rep_from_reg || (rep_idx_reg != 3'd0);
                rep_idx_next = 3'(rep_idx_reg + 3'd1);
                if (3'(rep_idx_reg + 3'd1) == rep_cnt_reg)
                    phase_next = SEQ_LAST;
            end
            SEQ_LAST:
            begin
                if (cur_reg.at_file_end)
                    fin = 1'b1;
                else
                begin
                    h_en     = 1'b1;
                    h_byte   = cur_reg.in_byte;
                    complete = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (start_rep)
        begin
            phase_next    = SEQ_REPLAY;
            rep_idx_next  = 3'd0;
            rep_cnt_next  = rep_k;
            rep_from_next = rep_from;
            cur_load      = 1'b1;
        end

        if (fin)
        begin
            if (st_pre.mode == M_NAME || st_pre.mode == M_COLON)
            begin
                fe_res[0] = mk_res(TK_FORMAT_ERR, 8'h00);
                fe_res[1] = mk_res(TK_FILE_END, 8'h00);
                fe_n      = 2'd2;
            end
            else if (st_pre.mode == M_TEXT)
            begin
                fe_res[0] = mk_res(TK_FIELD_END, 8'h00);
                fe_res[1] = mk_res(TK_FILE_END, 8'h00);
                fe_n      = 2'd2;
            end
            else
            begin
                fe_res[0] = mk_res(TK_FILE_END, 8'h00);
                fe_n      = 2'd1;
            end
            st_pre   = start_state(drop_style_reg);
            complete = 1'b1;
        end

        if (complete)
            phase_next = SEQ_IDLE;
    end

    assign st_next = (cfg_wr && cfg_index == REG_DROP_STYLE) ? start_state(cfg_data[1:0]) :
                     h_en ? h_st : st_pre;
    assign nw      = h_en ? h_res : fe_res;
    assign nw_n    = h_en ? h_n : fe_n;

    // append this cycle's tokens behind those already built for the request
    always_comb
    begin
        logic [3:0] off;
        logic [3:0] sum;

        bld_next = bld_reg;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            off = 4'(i) - bld_cnt_reg;
            if (4'(i) >= bld_cnt_reg && off < {2'b00, nw_n})
                bld_next[i] = nw[off[1:0]];
        end
        sum      = bld_cnt_reg + {2'b00, nw_n};
        cnt_next = (sum > 4'(BUF_DEPTH)) ? 4'(BUF_DEPTH) : sum;
    end

    assign tok_valid = (ob_cnt_reg != 4'd0);
    assign out_fire  = tok_valid && !tok_stall;
    assign out_last  = ({1'b0, ob_ptr_reg} + 4'd1 == ob_cnt_reg);
    assign out_take  = (ob_cnt_reg == 4'd0) || (out_fire && out_last);
    assign move_bld  = bld_rdy_reg && out_take;
    assign move_new  = complete && (cnt_next != 4'd0) && out_take;

    assign tok_data.token_kind  = ob_reg[ob_ptr_reg].kind;
    assign tok_data.out_byte    = ob_reg[ob_ptr_reg].data;
    assign tok_data.last_of_run = out_last;

    always_comb
    begin
        ob_cnt_next  = ob_cnt_reg;
        ob_ptr_next  = ob_ptr_reg;
        bld_cnt_next = cnt_next;
        bld_rdy_next = bld_rdy_reg;

        if (out_fire)
        begin
            if (out_last)
            begin
                ob_cnt_next = 4'd0;
                ob_ptr_next = 3'd0;
            end
            else
                ob_ptr_next = 3'(ob_ptr_reg + 3'd1);
        end

        if (move_bld)
        begin
            ob_cnt_next  = bld_cnt_reg;
            ob_ptr_next  = 3'd0;
            bld_cnt_next = 4'd0;
            bld_rdy_next = 1'b0;
        end
        else if (complete)
        begin
            if (move_new)
            begin
                ob_cnt_next  = cnt_next;
                ob_ptr_next  = 3'd0;
                bld_cnt_next = 4'd0;
            end
            else if (cnt_next != 4'd0)
                bld_rdy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_style_reg  <= STYLE_SINGLE;
            name_limit_reg  <= 10'd997;
            chunk_limit_reg <= 16'd8191;
            phase_reg       <= SEQ_IDLE;
            st_reg          <= start_state(STYLE_SINGLE);
            rep_idx_reg     <= 3'd0;
            rep_cnt_reg     <= 3'd0;
            rep_from_reg    <= 1'b0;
            bld_cnt_reg     <= 4'd0;
            bld_rdy_reg     <= 1'b0;
            ob_cnt_reg      <= 4'd0;
            ob_ptr_reg      <= 3'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            st_reg       <= st_next;
            rep_idx_reg  <= rep_idx_next;
            rep_cnt_reg  <= rep_cnt_next;
            rep_from_reg <= rep_from_next;
            bld_cnt_reg  <= bld_cnt_next;
            bld_rdy_reg  <= bld_rdy_next;
            ob_cnt_reg   <= ob_cnt_next;
            ob_ptr_reg   <= ob_ptr_next;
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_DROP_STYLE:  drop_style_reg  <= cfg_data[1:0];
                    REG_NAME_LIMIT:  name_limit_reg  <= cfg_data[9:0];
                    REG_CHUNK_LIMIT: chunk_limit_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bld_reg <= bld_next;
        if (cur_load)
            cur_reg <= src_data;
        if (move_bld)
            ob_reg <= bld_reg;
        else if (move_new)
            ob_reg <= bld_next;
    end

endmodule

// ===== rtl/mmft_handle.sv =====
// ----------------------------------------------------------------------------
// Mail message field tokenizer byte handler
// Classifies one byte against the parser state and lists up to three tokens.
// ----------------------------------------------------------------------------
module mmft_handle
    import mmft_pkg::*;
(
    input  st_t              st,
    input  logic [7:0]       b,
    input  logic             mm,
    input  logic [9:0]       name_limit,
    input  logic [15:0]      chunk_eff,
    output st_t              st_next,
    output res_t [2:0]       res,
    output logic [1:0]       res_n
);

    always_comb
    begin
        logic       delimited;
        logic [7:0] d0;
        logic       do_line;
        logic       line_mm;
        logic [16:0] cc_inc;
        logic [16:0] ec;

        st_next   = st;
        res       = '0;
        res_n     = 2'd0;
        do_line   = 1'b0;
        line_mm   = 1'b0;
        delimited = (st.style == STYLE_MBOX) || (st.style == STYLE_CTLA);
        d0        = delim_byte(st.style, 3'd0);
        ec        = {1'b0, chunk_eff};
        cc_inc    = {1'b0, st.chunk_cnt} + 17'd1;

        case (st.mode)
            M_LINE:
            begin
                do_line = 1'b1;
                line_mm = mm;
            end
            M_NAME:
            begin
                if (b == CH_COLON)
                begin
                    st_next.mode      = M_COLON;
                    st_next.chunk_cnt = '0;
                end
                else if (b == CH_NL)
                begin
                    if (ec < {7'd0, st.name_cnt} + 17'd2)
                    begin
                        res[0]       = mk_res(TK_FORMAT_ERR, 8'h00);
                        res_n        = 2'd1;
                        st_next.mode = M_ERROR;
                    end
                    else
                    begin
                        res[0]             = mk_res(TK_LINE_BODY, 8'h00);
                        res[1]             = mk_res(TK_BODY, CH_NL);
                        res_n              = 2'd2;
                        st_next.mode       = M_BODY;
                        st_next.line_start = 1'b1;
                        cc_inc             = {7'd0, st.name_cnt} + 17'd1;
                        if (cc_inc >= ec)
                        begin
                            res[2]            = mk_res(TK_BODY_CHUNK, 8'h00);
                            res_n             = 2'd3;
                            st_next.chunk_cnt = '0;
                        end
                        else
                            st_next.chunk_cnt = cc_inc[15:0];
                    end
                end
                else if (st.name_cnt >= name_limit)
                begin
                    res[0]       = mk_res(TK_LENGTH_ERR, 8'h00);
                    res_n        = 2'd1;
                    st_next.mode = M_ERROR;
                end
                else
                begin
                    res[0]           = mk_res(TK_NAME, b);
                    res_n            = 2'd1;
                    st_next.name_cnt = 10'(st.name_cnt + 10'd1);
                end
            end
            M_COLON, M_TEXT:
            begin
                if (st.nl_pend && b != CH_SPACE && b != CH_TAB)
                begin
                    res[0]            = mk_res(TK_FIELD_END, 8'h00);
                    res_n             = 2'd1;
                    st_next.nl_pend   = 1'b0;
                    st_next.name_cnt  = '0;
                    st_next.chunk_cnt = '0;
                    st_next.mode      = M_LINE;
                    do_line           = 1'b1;
                    line_mm           = 1'b1;
                end
                else
                begin
                    st_next.nl_pend = (b == CH_NL);
                    st_next.mode    = M_TEXT;
                    res[0]          = mk_res(TK_TEXT, b);
                    if (cc_inc >= ec)
                    begin
                        res[1]            = mk_res(TK_FIELD_CHUNK, 8'h00);
                        res_n             = 2'd2;
                        st_next.chunk_cnt = '0;
                    end
                    else
                    begin
                        res_n             = 2'd1;
                        st_next.chunk_cnt = cc_inc[15:0];
                    end
                end
            end
            M_SEP:
            begin
                if (b == CH_NL)
                begin
                    st_next.mode       = M_BODY;
                    st_next.chunk_cnt  = '0;
                    st_next.line_start = 1'b1;
                end
            end
            M_BODY:
            begin
                if (st.line_start && mm && delimited && b == d0)
                    st_next.match_cnt = 3'd1;
                else
                begin
                    res[0]             = mk_res(TK_BODY, b);
                    st_next.line_start = (b == CH_NL);
                    if (cc_inc >= ec)
                    begin
                        res[1]            = mk_res(TK_BODY_CHUNK, 8'h00);
                        res_n             = 2'd2;
                        st_next.chunk_cnt = '0;
                    end
                    else
                    begin
                        res_n             = 2'd1;
                        st_next.chunk_cnt = cc_inc[15:0];
                    end
                end
            end
            M_SKIP:
            begin
                if (b == CH_NL)
                    st_next.mode = M_LINE;
            end
            default:
            begin
            end
        endcase

        if (do_line)
        begin
            if (line_mm && delimited && b == d0)
                st_next.match_cnt = 3'd1;
            else if (b == CH_NL)
            begin
                st_next.mode       = M_BODY;
                st_next.chunk_cnt  = '0;
                st_next.line_start = 1'b1;
            end
            else if (b == CH_DASH)
                st_next.mode = M_SEP;
            else if (b == CH_COLON)
            begin
                st_next.mode      = M_COLON;
                st_next.chunk_cnt = '0;
            end
            else if (st_next.name_cnt >= name_limit)
            begin
                res[res_n]   = mk_res(TK_LENGTH_ERR, 8'h00);
                res_n        = 2'(res_n + 2'd1);
                st_next.mode = M_ERROR;
            end
            else
            begin
                res[res_n]       = mk_res(TK_NAME, b);
                res_n            = 2'(res_n + 2'd1);
                st_next.name_cnt = 10'd1;
                st_next.mode     = M_NAME;
            end
        end

        if (res_n != 2'd0)
            st_next.msg_open = 1'b1;
    end

endmodule

// ===== bench/mail_message_field_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// Mail message field tokenizer testbench
// Feeds mail files byte by byte under several drop styles and limits,
// predicts the token stream of every byte request and compares each token
// in order, with random gaps on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module mail_message_field_tokenizer_tb;
    import mmft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DELIM_CAP   = 5;
    localparam int CYCLE_LIMIT = 600000;

    class token_ledger;
        logic [1:0] reg_style;
        int         name_lim;
        int         chunk_lim;
        mode_t      mode;
        logic [1:0] style;
        int         name_cnt;
        int         chunk_cnt;
        int         match_cnt;
        bit         nl_pend;
        bit         line_start;
        bit         msg_open;
        res_t       step_tokens[$];
        tok_t       expected_tokens[$];
        int         fails;
        int         tokens_seen;
        int         requests_seen;

        function void restart_file();
            style      = reg_style;
            mode       = M_LINE;
            name_cnt   = 0;
            chunk_cnt  = 0;
            match_cnt  = 0;
            nl_pend    = 0;
            line_start = 1;
            msg_open   = 0;
        endfunction

        function void reset_all();
            reg_style = STYLE_SINGLE;
            name_lim  = 997;
            chunk_lim = 8191;
            restart_file();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == REG_DROP_STYLE)
            begin
                reg_style = val[1:0];
                restart_file();
            end
            else if (idx == REG_NAME_LIMIT)
                name_lim = val[9:0];
            else if (idx == REG_CHUNK_LIMIT)
                chunk_lim = val;
        endfunction

        function void put(logic [3:0] k, logic [7:0] b);
            if (step_tokens.size() >= 8)
                return;
            step_tokens.push_back({k, b});
            if (k != TK_MSG_END && k != TK_FILE_END)
                msg_open = 1;
        endfunction

        function int delim_len();
            int full;
            full = (style == STYLE_MBOX) ? 6 : ((style == STYLE_CTLA) ? 5 : 0);
            if (full == 0)
                return 0;
            return 1 + ((full - 1) < DELIM_CAP ? (full - 1) : DELIM_CAP);
        endfunction

        function logic [7:0] delim_at(int i);
            logic [7:0] mbox [6];
            mbox = '{CH_NL, "F", "r", "o", "m", CH_SPACE};
            if (style == STYLE_MBOX)
                return i < 6 ? mbox[i] : 8'h00;
            if (i < 4)
                return CH_CTLA;
            return i == 4 ? CH_NL : 8'h00;
        endfunction

        function logic [7:0] from_at(int i);
            logic [7:0] w [5];
            w = '{"F", "r", "o", "m", CH_SPACE};
            return w[i];
        endfunction

        function int chunk_cap();
            return chunk_lim < 3 ? 3 : chunk_lim;
        endfunction

        function void fail_with(logic [3:0] k);
            put(k, 8'h00);
            mode = M_ERROR;
        endfunction

        function void text_byte(logic [7:0] b);
            put(TK_TEXT, b);
            chunk_cnt++;
            if (chunk_cnt >= chunk_cap())
            begin
                put(TK_FIELD_CHUNK, 8'h00);
                chunk_cnt = 0;
            end
        endfunction

        function void body_byte(logic [7:0] b);
            put(TK_BODY, b);
            chunk_cnt++;
            if (chunk_cnt >= chunk_cap())
            begin
                put(TK_BODY_CHUNK, 8'h00);
                chunk_cnt = 0;
            end
            line_start = (b == CH_NL);
        endfunction

        function void end_message();
            if (msg_open)
                put(TK_MSG_END, 8'h00);
            msg_open   = 0;
            name_cnt   = 0;
            chunk_cnt  = 0;
            match_cnt  = 0;
            nl_pend    = 0;
            line_start = 1;
            mode       = (style == STYLE_MBOX) ? M_SKIP : M_LINE;
        endfunction

        function void begin_hold();
            match_cnt = 1;
            if (1 >= delim_len())
                end_message();
        endfunction

        function void parse_byte(logic [7:0] b, bit may_match);
            bit delimited;
            delimited = delim_len() != 0;
            case (mode)
                M_LINE:
                begin
                    if (may_match && delimited && b == delim_at(0))
                        begin_hold();
                    else if (b == CH_NL)
                    begin
                        mode = M_BODY;
                        chunk_cnt = 0;
                        line_start = 1;
                    end
                    else if (b == CH_DASH)
                        mode = M_SEP;
                    else if (b == CH_COLON)
                    begin
                        mode = M_COLON;
                        chunk_cnt = 0;
                    end
                    else if (name_cnt >= name_lim)
                        fail_with(TK_LENGTH_ERR);
                    else
                    begin
                        put(TK_NAME, b);
                        name_cnt = 1;
                        mode = M_NAME;
                    end
                end
                M_NAME:
                begin
                    if (b == CH_COLON)
                    begin
                        mode = M_COLON;
                        chunk_cnt = 0;
                    end
                    else if (b == CH_NL)
                    begin
                        if (chunk_cap() < name_cnt + 2)
                            fail_with(TK_FORMAT_ERR);
                        else
                        begin
                            put(TK_LINE_BODY, 8'h00);
                            mode = M_BODY;
                            chunk_cnt = name_cnt;
                            body_byte(CH_NL);
                        end
                    end
                    else if (name_cnt >= name_lim)
                        fail_with(TK_LENGTH_ERR);
                    else
                    begin
                        put(TK_NAME, b);
                        name_cnt++;
                    end
                end
                M_COLON, M_TEXT:
                begin
                    if (nl_pend && b != CH_SPACE && b != CH_TAB)
                    begin
                        put(TK_FIELD_END, 8'h00);
                        nl_pend = 0;
                        name_cnt = 0;
                        chunk_cnt = 0;
                        mode = M_LINE;
                        parse_byte(b, 1);
                    end
                    else
                    begin
                        nl_pend = (b == CH_NL);
                        mode = M_TEXT;
                        text_byte(b);
                    end
                end
                M_SEP:
                begin
                    if (b == CH_NL)
                    begin
                        mode = M_BODY;
                        chunk_cnt = 0;
                        line_start = 1;
                    end
                end
                M_BODY:
                begin
                    if (line_start && may_match && delimited && b == delim_at(0))
                        begin_hold();
                    else
                        body_byte(b);
                end
                M_SKIP:
                begin
                    if (b == CH_NL)
                        mode = M_LINE;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void replay_delim(int k);
            for (int i = 0; i < k; i++)
                take_byte(delim_at(i), i != 0);
        endfunction

        function void take_byte(logic [7:0] b, bit may_match);
            int k;
            if (style == STYLE_DETECT)
            begin
                k = match_cnt < 5 ? match_cnt : 0;
                if (b == from_at(k))
                begin
                    k++;
                    match_cnt = k;
                    if (k >= 5)
                    begin
                        style = STYLE_MBOX;
                        match_cnt = 0;
                        mode = M_SKIP;
                    end
                    return;
                end
                style = STYLE_CTLA;
                match_cnt = 0;
                for (int i = 0; i < k; i++)
                    take_byte(from_at(i), 1);
                take_byte(b, 1);
                return;
            end
            if (match_cnt > 0 && delim_len() != 0)
            begin
                k = match_cnt;
                if (k < delim_len() && b == delim_at(k))
                begin
                    match_cnt = k + 1;
                    if (k + 1 >= delim_len())
                        end_message();
                    return;
                end
                match_cnt = 0;
                replay_delim(k);
                take_byte(b, 1);
                return;
            end
            match_cnt = 0;
            parse_byte(b, may_match);
        endfunction

        function void close_file();
            int k;
            if (style == STYLE_DETECT)
            begin
                k = match_cnt < 5 ? match_cnt : 0;
                style = STYLE_CTLA;
                match_cnt = 0;
                for (int i = 0; i < k; i++)
                    take_byte(from_at(i), 1);
            end
            while (match_cnt > 0 && delim_len() != 0)
            begin
                k = match_cnt;
                match_cnt = 0;
                if (!(style == STYLE_MBOX && k == 1))
                    replay_delim(k);
            end
            match_cnt = 0;
            if (mode == M_NAME || mode == M_COLON)
                put(TK_FORMAT_ERR, 8'h00);
            else if (mode == M_TEXT)
                put(TK_FIELD_END, 8'h00);
            put(TK_FILE_END, 8'h00);
            restart_file();
        endfunction

        function void note_request(src_t d);
            tok_t t;
            step_tokens.delete();
            requests_seen++;
            if (d.at_file_end)
                close_file();
            else
                take_byte(d.in_byte, 1);
            foreach (step_tokens[i])
            begin
                t.token_kind  = step_tokens[i].kind;
                t.out_byte    = step_tokens[i].data;
                t.last_of_run = (i == step_tokens.size() - 1);
                expected_tokens.push_back(t);
            end
        endfunction

        function void check_token(tok_t got);
            tok_t want;
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected token kind=%0d byte=%h last=%0b", $realtime,
                         got.token_kind, got.out_byte, got.last_of_run);
                fails++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind != want.token_kind)
            begin
                $display("%0t: token_kind expected %0d actual %0d", $realtime,
                         want.token_kind, got.token_kind);
                fails++;
            end
            if (got.out_byte != want.out_byte)
            begin
                $display("%0t: out_byte expected %h actual %h", $realtime,
                         want.out_byte, got.out_byte);
                fails++;
            end
            if (got.last_of_run != want.last_of_run)
            begin
                $display("%0t: last_of_run expected %0b actual %0b", $realtime,
                         want.last_of_run, got.last_of_run);
                fails++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_stall;
    src_t        src_data = '0;
    logic        tok_valid;
    logic        tok_stall = 1'b0;
    tok_t        tok_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_DROP_STYLE;
    logic [15:0] cfg_data = '0;

    token_ledger ledger = new();
    logic [7:0]  file_bytes[$];
    bit          tx_calm;
    bit          rx_calm;
    bit          hold_off = 1'b0;
    bit          hold_go = 1'b0;
    int          rx_wait;
    int          cycles;
    int          files_sent;

    mail_message_field_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int draw_wait(bit calm);
        if (calm)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 16);
        return $urandom_range(0, 2);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("mail_message_field_tokenizer_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_valid && !tok_stall)
            begin
                ledger.check_token(tok_data);
                rx_wait = draw_wait(rx_calm);
            end
            else if (rx_wait > 0)
                rx_wait--;
            tok_stall <= hold_off || (rx_wait > 0);
        end
    end

    // hold the output side off so the block backs up into its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_request(logic [7:0] b, logic eof);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= '{in_byte: b, at_file_end: eof};
        do
            @(posedge clk);
        while (src_stall);
        ledger.note_request('{in_byte: b, at_file_end: eof});
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_request(file_bytes[i], 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
        file_bytes.delete();
        files_sent++;
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        while (ledger.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ledger.write_reg(idx, val);
    endtask

    task automatic set_limits(logic [1:0] sty, logic [15:0] nl, logic [15:0] cl);
        drain();
        write_reg(REG_NAME_LIMIT, nl);
        write_reg(REG_CHUNK_LIMIT, cl);
        write_reg(REG_DROP_STYLE, {14'd0, sty});
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(0, 255));
            1:       return CH_SPACE;
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic void add_message(bit broken);
        int n;
        n = $urandom_range(1, 2);
        for (int h = 0; h < n; h++)
        begin
            for (int i = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 12 : 5); i > 0; i--)
                file_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
            if (!(broken && $urandom_range(0, 2) == 0))
                file_bytes.push_back(CH_COLON);
            for (int i = $urandom_range(0, 5); i > 0; i--)
                file_bytes.push_back(pick_char());
            file_bytes.push_back(CH_NL);
            if ($urandom_range(0, 3) == 0)
            begin
                file_bytes.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
                add_text("more\n");
            end
        end
        file_bytes.push_back($urandom_range(0, 5) == 0 ? CH_DASH : CH_NL);
        if (file_bytes[$] == CH_DASH)
            add_text("--\n");
        for (int l = $urandom_range(0, 2); l > 0; l--)
        begin
            for (int i = $urandom_range(0, 6); i > 0; i--)
                file_bytes.push_back(pick_char());
            file_bytes.push_back(CH_NL);
        end
    endfunction

    function automatic void add_delim(bit mbox);
        if (mbox)
            add_text("\nFrom x\n");
        else
            add_text("\001\001\001\001\n");
        if ($urandom_range(0, 3) == 0)
            add_text(mbox ? "\nFro" : "\001\001");
    endfunction

    function automatic void make_file(logic [1:0] sty);
        bit mbox;
        bit broken;
        mbox = (sty == STYLE_MBOX);
        if (sty == STYLE_DETECT)
        begin
            mbox = 1'($urandom_range(0, 1));
            if (mbox)
                add_text("From a\n");
            else if ($urandom_range(0, 1))
                add_text("Fro");
        end
        broken = ($urandom_range(0, 4) == 0);
        for (int m = $urandom_range(1, 2); m > 0; m--)
        begin
            if (sty != STYLE_SINGLE && $urandom_range(0, 1))
                add_delim(mbox);
            add_message(broken);
        end
        if (broken && file_bytes.size() > 2)
            file_bytes = file_bytes[0:$urandom_range(1, file_bytes.size() - 1)];
    endfunction

    initial
    begin
        logic [1:0]  sty_tab [7];
        logic [15:0] name_tab [7];
        logic [15:0] chunk_tab [7];
        sty_tab   = '{STYLE_SINGLE, STYLE_DETECT, STYLE_MBOX, STYLE_CTLA,
                      STYLE_DETECT, STYLE_MBOX, STYLE_CTLA};
        name_tab  = '{16'd997, 16'd998, 16'd6, 16'd2, 16'd4, 16'd998, 16'd10};
        chunk_tab = '{16'd8191, 16'd65535, 16'd5, 16'd2, 16'd3, 16'd2, 16'd7};
        ledger.reset_all();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, separators, line without colon, errors
        set_limits(STYLE_CTLA, 16'd2, 16'd2);
        add_text("ab:");
        file_bytes.push_back(8'hFF);
        add_text("\n x\n-z\n");
        file_bytes.push_back(8'h00);
        file_bytes.push_back(CH_CTLA);
        file_bytes.push_back(CH_CTLA);
        add_text("q");
        send_file();
        add_text("abc");
        send_file();
        set_limits(STYLE_DETECT, 16'd998, 16'd65535);
        add_text("Frx");
        send_file();
        add_text("ab\n");
        send_file();

        for (int p = 0; p < 7; p++)
        begin
            set_limits(sty_tab[p], name_tab[p], chunk_tab[p]);
            tx_calm = (p % 3 == 1);
            rx_calm = (p % 3 == 2);
            if (p == 2)
            begin
                tx_calm = 1'b1;
                hold_go = 1'b1;
            end
            for (int n = ledger.requests_seen; ledger.requests_seen < n + 20; )
            begin
                make_file(sty_tab[p]);
                send_file();
            end
        end
        drain();
        $display("covered %0d files, %0d byte requests, %0d tokens checked",
                 files_sent, ledger.requests_seen, ledger.tokens_seen);
        $display("all four drop styles, name limits 2..998, chunk limits 2..65535");
        if (ledger.fails == 0)
            $display("mail_message_field_tokenizer_tb passed");
        else
            $display("mail_message_field_tokenizer_tb failed");
        $finish;
    end

endmodule
